// File: sv/flc_pkg.sv
// ----------------------------------------------------------------------------
// flc_pkg
// Shared constants and the per-cell control bundle of the convolution chain.
// ----------------------------------------------------------------------------
`default_nettype none

package flc_pkg;

    localparam int TAPS_MAX    = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int CONV_W      = 38;
    localparam int COUNT_W     = $clog2(TAPS_MAX + 1);

    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    typedef struct packed {
        logic step;      // advance the partial sums
        logic clear;     // drop the sample history
        logic coeff_wr;  // take a new coefficient
        logic active;    // cell lies below the coefficient count
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/flc_cell.sv
// ----------------------------------------------------------------------------
// flc_cell
// One tap of the transposed convolution chain: holds a coefficient and a
// partial sum, adds its product to the sum handed in by its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_cell
    import flc_pkg::*;
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire cell_ctrl_t                ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] coeff_in,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic signed [CONV_W-1:0]  p_in,
    output logic signed [CONV_W-1:0]       p_out
);

    logic signed [SAMPLE_BITS-1:0] coeff_reg;
    logic signed [CONV_W-1:0]      p_reg;
    logic signed [CONV_W-1:0]      p_next;
    logic signed [PROD_W-1:0]      prod;

    assign prod = coeff_reg * sample;

    always_comb
    begin
        if (ctrl.active)
        begin
            p_next = CONV_W'(prod) + p_in;
        end
        else
        begin
            p_next = p_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.coeff_wr)
        begin
            coeff_reg <= coeff_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            p_reg <= '0;
        end
        else if (ctrl.step)
        begin
            p_reg <= p_next;
        end
    end

    assign p_out = p_reg;

endmodule

`default_nettype wire

// File: sv/full_linear_convolution_1d.sv
// ----------------------------------------------------------------------------
// full_linear_convolution_1d
// Streaming full linear convolution of a sample vector with a loaded
// coefficient vector, exact in 38 bits.
//
// Usage: requests on the input channel (in_valid / in_stall) carry action,
// value and last. action = load writes the next coefficient (up to 32, extra
// loads are dropped); a load after samples starts a new coefficient vector
// and clears the history. action = sample pushes one sample and yields one
// result; a sample with last set also yields count-1 tail results, the final
// one flagged with result_last, and leaves the history cleared.
// Results leave on the output channel (out_valid / out_stall).
// A result is presented in the cycle after its sample is accepted.
// Throughput: one load or sample per cycle while the receiver does not stall; a
// last sample holds off the input while the tail drains through the cell chain.
// The chain is 32 cells in transposed form, one multiply-add per cell.
// Reset clears coefficient count, history and the output register.
// A stalled receiver holds the output register and, with it, the input.
// ----------------------------------------------------------------------------
`default_nettype none

module full_linear_convolution_1d
    import flc_pkg::*;
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic signed [SAMPLE_BITS-1:0] value,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic signed [CONV_W-1:0]           conv_value,
    output logic                               result_last
);

    // Sequencer states: take requests, or drain the tail after a last sample.
    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_TAIL = 1'b1;

    logic               state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] tail_cnt_reg, tail_cnt_next;
    logic               phase_reg, phase_next;
    logic               out_valid_reg, out_valid_next;
    logic               rlast_reg, rlast_next;

    logic               out_free;
    logic               in_acc;
    logic               load_acc;
    logic               sample_acc;
    logic               tail_step;
    logic               step;
    logic               tail_done;
    logic [COUNT_W-1:0] load_base;
    logic               load_wr;
    logic signed [SAMPLE_BITS-1:0] chain_x;

    logic signed [CONV_W-1:0] p_chain [TAPS_MAX+1];
    cell_ctrl_t               cell_ctrl [TAPS_MAX];

    // The output register frees up when empty or being taken this cycle.
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg == ST_TAIL) || !out_free;
    assign in_acc     = in_valid && !in_stall;
    assign load_acc   = in_acc && (action == ACTION_LOAD);
    assign sample_acc = in_acc && (action == ACTION_SAMPLE);
    assign tail_step  = (state_reg == ST_TAIL) && out_free;
    assign step       = sample_acc || tail_step;
    assign tail_done  = (tail_cnt_reg + COUNT_W'(1)) == count_reg;

    // Tail cycles feed zeros into the chain.
    assign chain_x = (state_reg == ST_TAIL) ? '0 : value;

    // A load after samples restarts the coefficient vector at index zero.
    assign load_base = phase_reg ? '0 : count_reg;
    assign load_wr   = load_acc && (load_base < COUNT_W'(TAPS_MAX));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        tail_cnt_next  = tail_cnt_reg;
        phase_next     = phase_reg;
        rlast_next     = rlast_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (load_acc)
        begin
            phase_next = 1'b0;
            count_next = load_wr ? load_base + COUNT_W'(1) : load_base;
        end

        if (sample_acc)
        begin
            phase_next     = 1'b1;
            out_valid_next = 1'b1;
            rlast_next     = last && (count_reg <= COUNT_W'(1));
            if (last && (count_reg > COUNT_W'(1)))
            begin
                state_next    = ST_TAIL;
                tail_cnt_next = COUNT_W'(1);
            end
        end

        if (tail_step)
        begin
            out_valid_next = 1'b1;
            rlast_next     = tail_done;
            if (tail_done)
            begin
                state_next = ST_RUN;
            end
            else
            begin
                tail_cnt_next = tail_cnt_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            count_reg     <= '0;
            tail_cnt_reg  <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            rlast_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tail_cnt_reg  <= tail_cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            rlast_reg     <= rlast_next;
        end
    end

    // Cell chain: cell k adds c[k]*x to the partial sum of cell k+1; the
    // partial sum of cell 0 is the finished result and doubles as the
    // output register.
    assign p_chain[TAPS_MAX] = '0;

    for (genvar k = 0; k < TAPS_MAX; k++)
    begin : g_cell
        always_comb
        begin
            cell_ctrl[k].step     = step;
            cell_ctrl[k].clear    = load_acc && phase_reg;
            cell_ctrl[k].coeff_wr = load_wr && (load_base == COUNT_W'(k));
            cell_ctrl[k].active   = COUNT_W'(k) < count_reg;
        end

        flc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl[k]),
            .coeff_in (value),
            .sample   (chain_x),
            .p_in     (p_chain[k+1]),
            .p_out    (p_chain[k])
        );
    end

    assign out_valid   = out_valid_reg;
    assign conv_value  = p_chain[0];
    assign result_last = rlast_reg;

endmodule

`default_nettype wire
